// ===== design/mcgt_pkg.sv =====
// Package for the multicast sequence gap tracker.
// Holds the status codes, the lookup result struct and the default sizes.
// Used by every module of the block; depends on nothing.
package mcgt_pkg;

  localparam int NUM_GROUPS_DEF = 16;
  localparam int SEQ_BITS_DEF   = 32;

  localparam int ADDR_W    = 32;
  localparam int SEQ_W     = 32;
  localparam int LEN_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 32;
  localparam int BYTES_W   = 48;

  localparam logic [LEN_W-1:0] EXP_LEN_RESET = 16'd1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_IN_ORDER   = 3'd0,
    ST_GAP        = 3'd1,
    ST_LATE       = 3'd2,
    ST_WRONG_LEN  = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic hit;   // the group already owns an entry
    logic full;  // new group and no free entry left
  } lookup_t;

endpackage

// ===== design/mcgt_lookup.sv =====
// Associative lookup of a group address over all table entries.
// Returns the matching entry, or the lowest free one for a new group.
// Depends on mcgt_pkg.
module mcgt_lookup #(
  parameter int NUM_GROUPS = mcgt_pkg::NUM_GROUPS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic [mcgt_pkg::ADDR_W-1:0] addr,
  input  logic [mcgt_pkg::ADDR_W-1:0] keys [NUM_GROUPS],
  input  logic [NUM_GROUPS-1:0]       valid,
  output mcgt_pkg::lookup_t           result,
  output logic [IDX_W-1:0]            slot
);

  logic [NUM_GROUPS-1:0] match;
  logic [IDX_W-1:0]      match_idx;
  logic [IDX_W-1:0]      free_idx;

  always_comb begin
    for (int i = 0; i < NUM_GROUPS; i++) begin
      match[i] = valid[i] && (keys[i] == addr);
    end
  end

  // Keys of valid entries are unique, so at most one match bit is set.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (match[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  // Scanning downward leaves the lowest free entry.
  always_comb begin
    free_idx = '0;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    result.hit  = |match;
    result.full = !(|match) && (&valid);
    slot        = result.hit ? match_idx : free_idx;
  end

endmodule

// ===== design/mcgt_update.sv =====
// Per-entry statistics update for one valid-length packet.
// Classifies the sequence number against the expected one and saturates counters.
// Depends on mcgt_pkg.
module mcgt_update #(
  parameter int SEQ_BITS = mcgt_pkg::SEQ_BITS_DEF
) (
  input  logic [SEQ_BITS-1:0]          seq,
  input  logic [mcgt_pkg::LEN_W-1:0]   len,
  input  logic [SEQ_BITS-1:0]          cur_exp,
  input  logic [SEQ_BITS-1:0]          cur_last,
  input  logic [mcgt_pkg::COUNT_W-1:0] cur_packets,
  input  logic [mcgt_pkg::BYTES_W-1:0] cur_bytes,
  input  logic [mcgt_pkg::COUNT_W-1:0] cur_drops,
  input  logic [mcgt_pkg::COUNT_W-1:0] cur_late,
  output mcgt_pkg::status_t            status,
  output logic [SEQ_BITS-1:0]          new_exp,
  output logic [SEQ_BITS-1:0]          new_last,
  output logic [mcgt_pkg::COUNT_W-1:0] new_packets,
  output logic [mcgt_pkg::BYTES_W-1:0] new_bytes,
  output logic [mcgt_pkg::COUNT_W-1:0] new_drops,
  output logic [mcgt_pkg::COUNT_W-1:0] new_late,
  output logic [mcgt_pkg::COUNT_W-1:0] gap
);

  localparam int CW = mcgt_pkg::COUNT_W;
  localparam int BW = mcgt_pkg::BYTES_W;

  logic [SEQ_BITS-1:0] gap_full;
  logic [CW-1:0]       gap_sat;
  logic [CW:0]         drops_sum;
  logic [BW:0]         bytes_sum;

  always_comb begin
    gap_full = seq - cur_exp;
    if (64'(gap_full) > 64'(CW'('1))) begin
      gap_sat = '1;
    end else begin
      gap_sat = CW'(gap_full);
    end
    drops_sum = {1'b0, cur_drops} + {1'b0, gap_sat};
    bytes_sum = {1'b0, cur_bytes} + (BW + 1)'(len);
  end

  always_comb begin
    status   = mcgt_pkg::ST_IN_ORDER;
    new_exp  = cur_exp;
    new_last = cur_last;
    new_drops = cur_drops;
    new_late  = cur_late;
    gap       = '0;
    priority if (seq == cur_exp) begin
      status   = mcgt_pkg::ST_IN_ORDER;
      new_exp  = cur_exp + 1'b1;
      new_last = seq;
    end else if (seq > cur_exp) begin
      status   = mcgt_pkg::ST_GAP;
      new_exp  = seq + 1'b1;
      new_last = seq;
      // The first packet of a group only sets the expected sequence.
      if (cur_packets != '0) begin
        gap       = gap_sat;
        new_drops = drops_sum[CW] ? '1 : drops_sum[CW-1:0];
      end
    end else begin
      status = mcgt_pkg::ST_LATE;
      if (cur_drops != '0) begin
        new_drops = cur_drops - 1'b1;
      end
      new_late = (cur_late == '1) ? cur_late : cur_late + 1'b1;
    end
  end

  always_comb begin
    new_packets = (cur_packets == '1) ? cur_packets : cur_packets + 1'b1;
    new_bytes   = bytes_sum[BW] ? '1 : bytes_sum[BW-1:0];
  end

endmodule

// ===== design/multicast_sequence_gap_tracker.sv =====
// Multicast sequence gap tracker: one packet record in, one result item out. Items are
// taken one per clock cycle unless out_ready stalls the result register, moving from the
// input register to the result register; the associative compare over all entries and
// the entry update sit between those two registers. Depends on mcgt_pkg, mcgt_lookup and
// mcgt_update. Entries are allocated lowest-free-first and never released; the user must
// write expected_length via the cfg channel only while idle; the block does not enforce it.
module multicast_sequence_gap_tracker #(
  parameter int NUM_GROUPS = mcgt_pkg::NUM_GROUPS_DEF,
  parameter int SEQ_BITS   = mcgt_pkg::SEQ_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcgt_pkg::LEN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcgt_pkg::ADDR_W-1:0]   group_addr,
  input  logic [mcgt_pkg::SEQ_W-1:0]    seq_num,
  input  logic [mcgt_pkg::LEN_W-1:0]    packet_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcgt_pkg::STATUS_W-1:0] status,
  output logic [mcgt_pkg::SLOT_W-1:0]   group_slot,
  output logic [mcgt_pkg::COUNT_W-1:0]  group_packets,
  output logic [mcgt_pkg::BYTES_W-1:0]  group_bytes,
  output logic [mcgt_pkg::COUNT_W-1:0]  group_drops,
  output logic [mcgt_pkg::COUNT_W-1:0]  group_out_of_order,
  output logic [mcgt_pkg::SEQ_W-1:0]    group_last_seq,
  output logic [mcgt_pkg::SEQ_W-1:0]    group_expected_seq,
  output logic [mcgt_pkg::COUNT_W-1:0]  gap_size,
  output logic [mcgt_pkg::COUNT_W-1:0]  wrong_length_count
);

  localparam int IDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CW    = mcgt_pkg::COUNT_W;
  localparam int BW    = mcgt_pkg::BYTES_W;

  // Configuration and global counter.
  logic [mcgt_pkg::LEN_W-1:0] expected_length;
  logic [CW-1:0]              wrong_length_counter;
  logic [CW-1:0]              wrong_length_counter_next;

  // Input register.
  logic                        s1_valid;
  logic [mcgt_pkg::ADDR_W-1:0] s1_addr;
  logic [mcgt_pkg::SEQ_W-1:0]  s1_seq;
  logic [mcgt_pkg::LEN_W-1:0]  s1_len;

  // Entry table.
  logic [NUM_GROUPS-1:0]       entry_valid;
  logic [mcgt_pkg::ADDR_W-1:0] key_table      [NUM_GROUPS];
  logic [SEQ_BITS-1:0]         exp_table      [NUM_GROUPS];
  logic [SEQ_BITS-1:0]         last_table     [NUM_GROUPS];
  logic [CW-1:0]               packets_table  [NUM_GROUPS];
  logic [BW-1:0]               bytes_table    [NUM_GROUPS];
  logic [CW-1:0]               drops_table    [NUM_GROUPS];
  logic [CW-1:0]               late_table     [NUM_GROUPS];

  // Datapath between the two registers.
  logic                 advance;
  logic                 len_ok;
  logic                 do_update;
  mcgt_pkg::lookup_t    lk;
  logic [IDX_W-1:0]     slot;
  logic [SEQ_BITS-1:0]  seq_m;
  logic [SEQ_BITS-1:0]  cur_exp;
  logic [SEQ_BITS-1:0]  cur_last;
  logic [CW-1:0]        cur_packets;
  logic [BW-1:0]        cur_bytes;
  logic [CW-1:0]        cur_drops;
  logic [CW-1:0]        cur_late;
  mcgt_pkg::status_t    upd_status;
  logic [SEQ_BITS-1:0]  new_exp;
  logic [SEQ_BITS-1:0]  new_last;
  logic [CW-1:0]        new_packets;
  logic [BW-1:0]        new_bytes;
  logic [CW-1:0]        new_drops;
  logic [CW-1:0]        new_late;
  logic [CW-1:0]        new_gap;

  // Result register.
  mcgt_pkg::status_t         r_status;
  logic [mcgt_pkg::SLOT_W-1:0] r_slot;
  logic [CW-1:0]             r_packets;
  logic [BW-1:0]             r_bytes;
  logic [CW-1:0]             r_drops;
  logic [CW-1:0]             r_late;
  logic [mcgt_pkg::SEQ_W-1:0] r_last;
  logic [mcgt_pkg::SEQ_W-1:0] r_exp;
  logic [CW-1:0]             r_gap;
  logic [CW-1:0]             r_wrong;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= mcgt_pkg::EXP_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_addr <= group_addr;
      s1_seq  <= seq_num;
      s1_len  <= packet_length;
    end
  end

  mcgt_lookup #(
    .NUM_GROUPS (NUM_GROUPS),
    .IDX_W      (IDX_W)
  ) u_lookup (
    .addr   (s1_addr),
    .keys   (key_table),
    .valid  (entry_valid),
    .result (lk),
    .slot   (slot)
  );

  // A freshly allocated entry starts from all zeros.
  always_comb begin
    seq_m     = SEQ_BITS'(s1_seq);
    len_ok    = (s1_len == expected_length);
    do_update = advance && len_ok && !lk.full;
    if (lk.hit) begin
      cur_exp     = exp_table[slot];
      cur_last    = last_table[slot];
      cur_packets = packets_table[slot];
      cur_bytes   = bytes_table[slot];
      cur_drops   = drops_table[slot];
      cur_late    = late_table[slot];
    end else begin
      cur_exp     = '0;
      cur_last    = '0;
      cur_packets = '0;
      cur_bytes   = '0;
      cur_drops   = '0;
      cur_late    = '0;
    end
    if (len_ok || wrong_length_counter == '1) begin
      wrong_length_counter_next = wrong_length_counter;
    end else begin
      wrong_length_counter_next = wrong_length_counter + 1'b1;
    end
  end

  mcgt_update #(
    .SEQ_BITS (SEQ_BITS)
  ) u_update (
    .seq         (seq_m),
    .len         (s1_len),
    .cur_exp     (cur_exp),
    .cur_last    (cur_last),
    .cur_packets (cur_packets),
    .cur_bytes   (cur_bytes),
    .cur_drops   (cur_drops),
    .cur_late    (cur_late),
    .status      (upd_status),
    .new_exp     (new_exp),
    .new_last    (new_last),
    .new_packets (new_packets),
    .new_bytes   (new_bytes),
    .new_drops   (new_drops),
    .new_late    (new_late),
    .gap         (new_gap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid          <= '0;
      wrong_length_counter <= '0;
    end else begin
      if (do_update) begin
        entry_valid[slot] <= 1'b1;
      end
      if (advance) begin
        wrong_length_counter <= wrong_length_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      key_table[slot]     <= s1_addr;
      exp_table[slot]     <= new_exp;
      last_table[slot]    <= new_last;
      packets_table[slot] <= new_packets;
      bytes_table[slot]   <= new_bytes;
      drops_table[slot]   <= new_drops;
      late_table[slot]    <= new_late;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Wrong-length and table-full items report only the status and the global counter.
  always_ff @(posedge clk) begin
    if (advance) begin
      r_wrong <= wrong_length_counter_next;
      if (do_update) begin
        r_status  <= upd_status;
        r_slot    <= mcgt_pkg::SLOT_W'(slot);
        r_packets <= new_packets;
        r_bytes   <= new_bytes;
        r_drops   <= new_drops;
        r_late    <= new_late;
        r_last    <= mcgt_pkg::SEQ_W'(new_last);
        r_exp     <= mcgt_pkg::SEQ_W'(new_exp);
        r_gap     <= new_gap;
      end else begin
        r_status  <= len_ok ? mcgt_pkg::ST_TABLE_FULL : mcgt_pkg::ST_WRONG_LEN;
        r_slot    <= '0;
        r_packets <= '0;
        r_bytes   <= '0;
        r_drops   <= '0;
        r_late    <= '0;
        r_last    <= '0;
        r_exp     <= '0;
        r_gap     <= '0;
      end
    end
  end

  assign status             = r_status;
  assign group_slot         = r_slot;
  assign group_packets      = r_packets;
  assign group_bytes        = r_bytes;
  assign group_drops        = r_drops;
  assign group_out_of_order = r_late;
  assign group_last_seq     = r_last;
  assign group_expected_seq = r_exp;
  assign gap_size           = r_gap;
  assign wrong_length_count = r_wrong;

endmodule
